>>> rtl/core/jpc_pkg.sv
// Package for the joystick point to polar command block.
// Holds the widths, register indexes, word types and the stage type of the root chain.
// Depends on nothing.
`default_nettype none

package jpc_pkg;

  localparam int COORD_W   = 8;
  localparam int VAL_W     = 2 * COORD_W + 1;
  localparam int N_CELLS   = COORD_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [COORD_W-1:0] CENTER_X_RESET    = COORD_W'(100);
  localparam logic [COORD_W-1:0] CENTER_Y_RESET    = COORD_W'(100);
  localparam logic [COORD_W-1:0] MAX_RADIUS_RESET  = COORD_W'(100);
  localparam logic [COORD_W-1:0] CODE_OFFSET_RESET = COORD_W'(36);

  localparam logic KIND_POSITION = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_MAX_RADIUS,
    REG_CODE_OFFSET
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic               command_kind;
    logic [COORD_W-1:0] x_code;
    logic [COORD_W-1:0] y_code;
    logic [COORD_W-1:0] magnitude;
  } command_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] root;
    point_t           point;
  } root_stage_t;

endpackage

`default_nettype wire

>>> rtl/core/jpc_front.sv
// Front end of the joystick block: distance from the centre and its square.
// Two pipeline stages feeding the root chain; uses jpc_pkg.
`default_nettype none

module jpc_front
  import jpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               valid_i,
  input  wire point_t             point_i,
  input  wire logic [COORD_W-1:0] center_x,
  input  wire logic [COORD_W-1:0] center_y,
  output root_stage_t             stage_o
);

  logic               valid_a_r;
  logic [COORD_W-1:0] dx_a_r;
  logic [COORD_W-1:0] dy_a_r;
  point_t             point_a_r;
  logic [COORD_W-1:0] dx_nxt;
  logic [COORD_W-1:0] dy_nxt;

  logic               valid_b_r;
  logic [VAL_W-1:0]   sq_b_r;
  point_t             point_b_r;
  logic [2*COORD_W-1:0] dx_sq;
  logic [2*COORD_W-1:0] dy_sq;
  logic [VAL_W-1:0]   sq_nxt;

  always_comb begin
    dx_nxt = (point_i.point_x >= center_x) ? point_i.point_x - center_x
                                           : center_x - point_i.point_x;
    dy_nxt = (point_i.point_y >= center_y) ? point_i.point_y - center_y
                                           : center_y - point_i.point_y;
    dx_sq  = (2*COORD_W)'(dx_a_r) * (2*COORD_W)'(dx_a_r);
    dy_sq  = (2*COORD_W)'(dy_a_r) * (2*COORD_W)'(dy_a_r);
    sq_nxt = {1'b0, dx_sq} + {1'b0, dy_sq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= valid_i;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a_r    <= dx_nxt;
      dy_a_r    <= dy_nxt;
      point_a_r <= point_i;
      sq_b_r    <= sq_nxt;
      point_b_r <= point_a_r;
    end
  end

  assign stage_o = '{valid: valid_b_r, rem: sq_b_r, root: '0, point: point_b_r};

endmodule

`default_nettype wire

>>> rtl/core/jpc_cell.sv
// One cell of the square root chain: settles one result bit per cell.
// Restoring digit-by-digit step on the remainder and partial root; uses jpc_pkg.
`default_nettype none

module jpc_cell
  import jpc_pkg::*;
#(
  parameter int STEP = 0
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire root_stage_t stage_i,
  output root_stage_t      stage_o
);

  localparam logic [VAL_W-1:0] DIGIT =
    {{(VAL_W-1){1'b0}}, 1'b1} << (2 * (COORD_W - STEP));

  logic             valid_r;
  logic [VAL_W-1:0] rem_r;
  logic [VAL_W-1:0] root_r;
  point_t           point_r;
  logic [VAL_W-1:0] trial;
  logic [VAL_W-1:0] rem_nxt;
  logic [VAL_W-1:0] root_nxt;

  always_comb begin
    trial = stage_i.root + DIGIT;
    if (stage_i.rem >= trial) begin
      rem_nxt  = stage_i.rem - trial;
      root_nxt = (stage_i.root >> 1) + DIGIT;
    end else begin
      rem_nxt  = stage_i.rem;
      root_nxt = stage_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= rem_nxt;
      root_r  <= root_nxt;
      point_r <= stage_i.point;
    end
  end

  assign stage_o = '{valid: valid_r, rem: rem_r, root: root_r, point: point_r};

endmodule

`default_nettype wire

>>> rtl/core/joystick_point_to_polar_command.sv
// Top level of the joystick point to polar command block.
// Instantiates jpc_front and a chain of jpc_cell; uses jpc_pkg.
// The block accepts one word per cycle while the output is not stalled. Each word
// passes two front stages for the distance and its square, one chain cell per root
// bit, and the output register. The whole pipeline moves only while the output
// register is empty or being taken, so a stalled output holds every word in flight.
// A point whose distance exceeds max_radius gives no word. Configuration writes are
// always taken; the centre is applied as a word is accepted but the radius and
// offset only as it leaves the chain, so the registers should be written only while
// no word is in flight.
`default_nettype none

module joystick_point_to_polar_command
  import jpc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire point_t               in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output command_t                  out_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data
);

  logic [COORD_W-1:0] center_x_r;
  logic [COORD_W-1:0] center_y_r;
  logic [COORD_W-1:0] max_radius_r;
  logic [COORD_W-1:0] code_offset_r;

  logic        en;
  root_stage_t chain [0:N_CELLS];
  root_stage_t last;
  logic        out_valid_r;
  logic        out_valid_nxt;
  command_t    out_word_r;
  command_t    out_word_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= CENTER_X_RESET;
      center_y_r    <= CENTER_Y_RESET;
      max_radius_r  <= MAX_RADIUS_RESET;
      code_offset_r <= CODE_OFFSET_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:    center_x_r    <= cfg_data;
        REG_CENTER_Y:    center_y_r    <= cfg_data;
        REG_MAX_RADIUS:  max_radius_r  <= cfg_data;
        REG_CODE_OFFSET: code_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  jpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (in_valid),
    .point_i  (in_word),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .stage_o  (chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    jpc_cell #(
      .STEP (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  assign last = chain[N_CELLS];

  always_comb begin
    out_valid_nxt = last.valid && (last.root <= {{(VAL_W-COORD_W){1'b0}}, max_radius_r});
    out_word_nxt.command_kind = KIND_POSITION;
    out_word_nxt.x_code       = last.point.point_x + code_offset_r;
    out_word_nxt.y_code       = last.point.point_y + code_offset_r;
    out_word_nxt.magnitude    = last.root[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for joystick_point_to_polar_command: random touch points and pad settings.
// A scoreboard class predicts each position command from the points and register writes it sees.
// Depends on jpc_pkg and the joystick_point_to_polar_command RTL.
`timescale 1ns / 1ps

module testbench;
  import jpc_pkg::*;

  localparam int LATENCY = COORD_W + 4;

  class command_scoreboard;
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
    logic [COORD_W-1:0] radius;
    logic [COORD_W-1:0] offset;
    command_t expected_q[$];
    int mismatches;

    function new();
      centre_x = CENTER_X_RESET;
      centre_y = CENTER_Y_RESET;
      radius = MAX_RADIUS_RESET;
      offset = CODE_OFFSET_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t sel, logic [COORD_W-1:0] value);
      case (sel)
        REG_CENTER_X: centre_x = value;
        REG_CENTER_Y: centre_y = value;
        REG_MAX_RADIUS: radius = value;
        REG_CODE_OFFSET: offset = value;
        default: ;
      endcase
    endfunction

    function int unsigned floor_root(int unsigned value);
      int unsigned rest;
      int unsigned root;
      int unsigned probe;
      rest = value;
      root = 0;
      probe = 1 << (2 * COORD_W);
      while (probe > rest) probe >>= 2;
      while (probe != 0) begin
        if (rest >= root + probe) begin
          rest -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    function void note_point(point_t p);
      int unsigned dx;
      int unsigned dy;
      int unsigned mag;
      command_t cmd;
      dx = (p.point_x >= centre_x) ? p.point_x - centre_x : centre_x - p.point_x;
      dy = (p.point_y >= centre_y) ? p.point_y - centre_y : centre_y - p.point_y;
      mag = floor_root(dx * dx + dy * dy);
      if (mag <= radius) begin
        cmd.command_kind = KIND_POSITION;
        cmd.x_code = p.point_x + offset;
        cmd.y_code = p.point_y + offset;
        cmd.magnitude = mag[COORD_W-1:0];
        expected_q.push_back(cmd);
      end
    endfunction

    function void flag(string what, command_t want, command_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected kind %0d x %0d y %0d mag %0d, got kind %0d x %0d y %0d mag %0d",
                 $time, what, want.command_kind, want.x_code, want.y_code, want.magnitude,
                 got.command_kind, got.x_code, got.y_code, got.magnitude);
      end
    endfunction

    function void check_command(command_t got);
      command_t want;
      if (expected_q.size() == 0) begin
        flag("unexpected word", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.command_kind !== want.command_kind || got.x_code !== want.x_code ||
            got.y_code !== want.y_code || got.magnitude !== want.magnitude) begin
          flag("wrong word", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  point_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  command_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  command_scoreboard sb = new();

  joystick_point_to_polar_command dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note_point(in_word);
      if (out_valid && out_ready) sb.check_command(out_word);
    end
  end

  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COORD_W-1:0] point_near(logic [COORD_W-1:0] c,
                                                    logic [COORD_W-1:0] r);
    int v;
    v = int'(c) - int'(r) - 2 + int'($urandom_range(0, 2 * r + 4));
    if (v < 0) v = 0;
    if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return v[COORD_W-1:0];
  endfunction

  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{point_x: x, point_y: y};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 6) begin
        send_point(point_near(sb.centre_x, sb.radius), point_near(sb.centre_y, sb.radius));
      end else begin
        send_point(COORD_W'($urandom_range(0, (1 << COORD_W) - 1)),
                   COORD_W'($urandom_range(0, (1 << COORD_W) - 1)));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] off);
    logic [COORD_W-1:0] values [4];
    cfg_reg_t sel;
    values[REG_CENTER_X] = cx;
    values[REG_CENTER_Y] = cy;
    values[REG_MAX_RADIUS] = r;
    values[REG_CODE_OFFSET] = off;
    sel = sel.first();
    cfg_valid <= 1'b1;
    do begin
      cfg_index <= sel;
      cfg_data <= values[sel];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sel = sel.next();
    end while (sel != sel.first());
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: corners, the centre and both sides of the pad edge.
    send_point(0, 0);
    send_point(255, 255);
    send_point(0, 255);
    send_point(255, 0);
    send_point(100, 100);
    send_point(200, 100);
    send_point(201, 100);
    send_point(100, 0);
    send_point(100, 201);
    send_point(29, 29);
    send_point(28, 28);
    send_random(280);
    drain();

    // Full radius: magnitudes around the top of the field, codes that wrap.
    apply_settings(0, 0, 255, 255);
    send_point(0, 0);
    send_point(255, 0);
    send_point(180, 180);
    send_point(181, 181);
    send_point(182, 181);
    send_point(255, 255);
    send_random(260);
    drain();

    apply_settings(255, 255, 0, 0);
    send_random(260);
    drain();

    apply_settings(128, 64, 40, 200);
    send_random(260);
    drain();

    repeat (2) begin
      apply_settings(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
                     COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)));
      send_random(260);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("testbench: timed out with %0d words outstanding", sb.pending());
    $display("testbench: FAIL");
    $finish;
  end

endmodule
